// ----- rtl/hsl_saturation_set_core_assert.svh -----
// Assertion macros for the saturation-set core.
// Included by the top level; depends on nothing else.
`ifndef HSL_SATURATION_SET_CORE_ASSERT_SVH
`define HSL_SATURATION_SET_CORE_ASSERT_SVH

// Implication checked on every rising clock edge, off during reset.
`define HSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define HSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/hss_pkg.sv -----
// Shared constants and types for the saturation-set core.
// No dependencies.
package hss_pkg;
    localparam int unsigned HueFracBits = 12;
    localparam int unsigned HueW        = HueFracBits + 3;
    localparam int unsigned DivSteps    = HueFracBits + 1;
    localparam int unsigned Stages      = DivSteps + 5;
    localparam logic [8:0]  SatReset    = 9'd256;

    typedef struct packed {
        logic [7:0] alpha;
        logic       frame_end;
    } t_side;
endpackage

// ----- rtl/hsl_saturation_set_core.sv -----
// Saturation-set core: RGBA pixel in, RGBA pixel out with the HSL saturation
// replaced by a programmed level. Channels use valid/ready.
//
// Uses hss_pkg and the assertion macro header.
// One transaction per clock sustained while the receiver does not stall. The
// pipeline is the input stage and the restoring hue divider (integer bit
// first, then one fraction bit per stage), followed by the chroma multiply,
// the blend multiply, the channel sum and the output register.
// Every stage advances when the output register is free or being emptied,
// so a receiver stall holds the whole pipeline without losing or repeating a
// transaction; i_ready falls whenever the output register holds a stalled
// transaction.
// Reset clears all valid bits and sets the saturation level to 1.0 (256).
// Write the level only while the pipe is empty; values above 256 act as 256.
// Alpha and the end-of-frame mark ride along unchanged.
// The red, green and blue results are floor values clamped to 0..255.
module hsl_saturation_set_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       i_ready,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_alpha_in,
    input  logic       i_frame_end_in,
    output logic       o_valid,
    input  logic       o_ready,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_alpha_out,
    output logic       o_frame_end_out
);
    import hss_pkg::*;
`include "hsl_saturation_set_core_assert.svh"

    localparam int unsigned FB = HueFracBits;

    logic       adv;
    logic [8:0] r_sat;
    logic [8:0] sat_eff;

    assign adv     = !o_valid || o_ready;
    assign i_ready = adv;
    assign sat_eff = r_sat[8] ? SatReset : r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= SatReset;
        end else if (i_cfg_we) begin
            r_sat <= i_cfg_wdata;
        end
    end

    // Stage 0: max/min/sextant selection
    logic         r_v0;
    logic [8:0]   r_l2_0;
    logic [7:0]   r_dlt_0;
    logic [7:0]   r_n_0;
    logic         r_neg_0;
    logic [2:0]   r_base_0;
    t_side        r_sd_0;

    logic [7:0] cmax, cmin, nmag;
    logic [8:0] ndiff;
    logic [2:0] base;
    always_comb begin
        cmax = (i_red_in > i_green_in) ? i_red_in : i_green_in;
        if (i_blue_in > cmax) cmax = i_blue_in;
        cmin = (i_red_in < i_green_in) ? i_red_in : i_green_in;
        if (i_blue_in < cmin) cmin = i_blue_in;
        if (cmax == i_red_in) begin
            ndiff = {1'b0, i_green_in} - {1'b0, i_blue_in};
            base  = 3'd0;
        end else if (cmax == i_green_in) begin
            ndiff = {1'b0, i_blue_in} - {1'b0, i_red_in};
            base  = 3'd2;
        end else begin
            ndiff = {1'b0, i_red_in} - {1'b0, i_green_in};
            base  = 3'd4;
        end
        nmag = ndiff[8] ? 8'(-ndiff) : ndiff[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l2_0   <= {1'b0, cmax} + {1'b0, cmin};
            r_dlt_0  <= cmax - cmin;
            r_n_0    <= nmag;
            r_neg_0  <= ndiff[8];
            r_base_0 <= base;
            r_sd_0   <= '{alpha: i_alpha_in, frame_end: i_frame_end_in};
        end
    end

    // Restoring divider: (n << FB) / delta, one quotient bit per stage.
    // n <= delta, so the quotient fits in FB + 1 bits; steps run MSB first.
    logic [DivSteps-1:0] r_dv;
    logic [8:0]          r_rem [DivSteps];
    logic [FB:0]         r_q   [DivSteps];
    logic [7:0]          r_dd  [DivSteps];
    logic                r_dng [DivSteps];
    logic [2:0]          r_dbs [DivSteps];
    logic [8:0]          r_dl2 [DivSteps];
    t_side               r_dsd [DivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (adv) begin
            r_dv <= {r_dv[DivSteps-2:0], r_v0};
        end
    end

    // First divider stage takes the integer bit (set when n equals delta).
    logic take0;
    assign take0 = (r_dlt_0 != 8'd0) && (r_n_0 >= r_dlt_0);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0] <= take0 ? {1'b0, r_n_0 - r_dlt_0} : {1'b0, r_n_0};
            r_q[0]   <= {{FB{1'b0}}, take0};
            r_dd[0]  <= r_dlt_0;
            r_dng[0] <= r_neg_0;
            r_dbs[0] <= r_base_0;
            r_dl2[0] <= r_l2_0;
            r_dsd[0] <= r_sd_0;
        end
    end

    for (genvar k = 1; k < DivSteps; k++) begin : g_div
        logic [9:0] trial;
        logic       take;
        assign trial = {r_rem[k-1], 1'b0} - {2'b0, r_dd[k-1]};
        assign take  = !trial[9] && (r_dd[k-1] != 8'd0);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem[k] <= take ? trial[8:0] : {r_rem[k-1][7:0], 1'b0};
                r_q[k]   <= {r_q[k-1][FB-1:0], take};
                r_dd[k]  <= r_dd[k-1];
                r_dng[k] <= r_dng[k-1];
                r_dbs[k] <= r_dbs[k-1];
                r_dl2[k] <= r_dl2[k-1];
                r_dsd[k] <= r_dsd[k-1];
            end
        end
    end

    // Stage H: hue assembly and chroma a*s
    localparam int unsigned L = DivSteps - 1;
    logic              r_vh;
    logic [HueW-1:0]   r_hue_h;
    logic [16:0]       r_cs_h;
    logic [8:0]        r_l2_h;
    t_side             r_sd_h;

    logic [HueW-1:0] hue_c;
    logic [HueW:0]   hsum;
    logic [8:0]      a_c, dl;
    always_comb begin
        hsum = '0;
        if (r_dd[L] == 8'd0) begin
            hue_c = '0;
        end else begin
            if (!r_dng[L]) begin
                hsum = {1'b0, r_dbs[L], {FB{1'b0}}} + {3'b0, r_q[L]};
            end else if (r_dbs[L] == 3'd0) begin
                hsum = {1'b0, 3'd6, {FB{1'b0}}} - {3'b0, r_q[L]};
            end else begin
                hsum = {1'b0, r_dbs[L], {FB{1'b0}}} - {3'b0, r_q[L]};
            end
            hue_c = (hsum[HueW-1 -: 3] >= 3'd6) ? '0 : hsum[HueW-1:0];
        end
        dl  = (r_dl2[L] >= 9'd255) ? r_dl2[L] - 9'd255 : 9'd255 - r_dl2[L];
        a_c = 9'd255 - dl;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vh <= 1'b0;
        end else if (adv) begin
            r_vh <= r_dv[DivSteps-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hue_h <= hue_c;
            r_cs_h  <= 17'(a_c[7:0] * sat_eff);
            r_l2_h  <= r_dl2[L];
            r_sd_h  <= r_dsd[L];
        end
    end

    // Stage X: xd = cs * w
    logic             r_vx;
    logic [2:0]       r_sx_x;
    logic [16:0]      r_cs_x;
    logic [17+FB-1:0] r_xd_x;
    logic [8:0]       r_l2_x;
    t_side            r_sd_x;

    logic [FB:0] tfr, w_c;
    always_comb begin
        tfr = {r_hue_h[FB], r_hue_h[FB-1:0]};
        // t in [0,2): w = 1 - |t - 1|
        w_c = tfr[FB] ? ({1'b1, {FB{1'b0}}} - {1'b0, tfr[FB-1:0]})
                      : {1'b0, tfr[FB-1:0]};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= 1'b0;
        end else if (adv) begin
            r_vx <= r_vh;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sx_x <= r_hue_h[HueW-1 -: 3];
            r_cs_x <= r_cs_h;
            r_xd_x <= (17+FB)'(r_cs_h * w_c);
            r_l2_x <= r_l2_h;
            r_sd_x <= r_sd_h;
        end
    end

    // Stage C: channel numerators 2*c + l2*D - cd, then floor by 2D and clamp
    localparam int unsigned NW = 9 + 8 + FB + 3;
    logic             r_vc;
    logic [NW-1:0]    r_nr_c, r_ng_c, r_nb_c;
    t_side            r_sd_c;

    logic [NW-1:0] cdw, xdw, md, pr, pg, pb;
    always_comb begin
        cdw = NW'({r_cs_x, {FB{1'b0}}});
        xdw = NW'(r_xd_x);
        md  = NW'({r_l2_x, {(8 + FB){1'b0}}}) - cdw;
        case (r_sx_x)
            3'd0: begin pr = cdw; pg = xdw; pb = '0;  end
            3'd1: begin pr = xdw; pg = cdw; pb = '0;  end
            3'd2: begin pr = '0;  pg = cdw; pb = xdw; end
            3'd3: begin pr = '0;  pg = xdw; pb = cdw; end
            3'd4: begin pr = xdw; pg = '0;  pb = cdw; end
            default: begin pr = cdw; pg = '0; pb = xdw; end
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (adv) begin
            r_vc <= r_vx;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nr_c <= {pr[NW-2:0], 1'b0} + md;
            r_ng_c <= {pg[NW-2:0], 1'b0} + md;
            r_nb_c <= {pb[NW-2:0], 1'b0} + md;
            r_sd_c <= r_sd_x;
        end
    end

    // md can be negative; sign is the top bit. Divide by 2D = 2^(9+FB).
    function automatic logic [7:0] clamp_ch(input logic [NW-1:0] v);
        logic [NW-1:0] q;
        q = v >> (9 + FB);
        if (v[NW-1]) begin
            return 8'd0;
        end else if (q > NW'(255)) begin
            return 8'd255;
        end else begin
            return q[7:0];
        end
    endfunction

    logic r_vo;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= r_vc;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_red_out       <= clamp_ch(r_nr_c);
            o_green_out     <= clamp_ch(r_ng_c);
            o_blue_out      <= clamp_ch(r_nb_c);
            o_alpha_out     <= r_sd_c.alpha;
            o_frame_end_out <= r_sd_c.frame_end;
        end
    end
    assign o_valid = r_vo;

    `HSS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && !o_ready, o_valid && $stable(o_red_out))
    `HSS_ASSERT_IMP(a_ready_rule, i_clk, i_rst_n, !i_ready, o_valid)
    `HSS_ASSERT_NEXT(a_pipe_moves, i_clk, i_rst_n, adv && r_vc, o_valid)
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the saturation-set core: directed table then random pixels,
// checked against a bit-exact HSL predictor. Depends on hss_pkg and the core.
module tb;
    import hss_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } t_pixel;

    typedef struct {
        t_pixel     pix;
        logic [9:0] sat;     // level written before this row, NoWrite = none
        logic       has_exp;
        t_pixel     exp_pix;
    } t_row;

    localparam int Latency = HueFracBits + 6;
    localparam int NumRandom = 1750;
    localparam logic [9:0] NoWrite = 10'h3ff;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_wdata = '0;
    logic       i_valid = 1'b0;
    logic       i_ready;
    logic [7:0] i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic       i_frame_end_in = 1'b0;
    logic       o_valid;
    logic       o_ready = 1'b0;
    logic [7:0] o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic       o_frame_end_out;

    logic [8:0] sat_level;
    t_pixel     pending_pixels[$];
    int         fail_count = 0;
    bit         stall_enable = 1'b1;

    hsl_saturation_set_core dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_valid, .i_ready,
        .i_red_in, .i_green_in, .i_blue_in, .i_alpha_in, .i_frame_end_in,
        .o_valid, .o_ready,
        .o_red_out, .o_green_out, .o_blue_out, .o_alpha_out, .o_frame_end_out
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [7:0] clamp_chan(longint num, longint den);
        longint v;
        if (num <= 0) return 8'd0;
        v = num / den;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_pixel resaturate(t_pixel p, logic [8:0] lvl);
        longint one, r, g, b, cmax, cmin, delta, hue, l2, a, s, cs, cd, t, w, xd;
        longint den, md, n, base, frac, cr, cg, cb;
        t_pixel q;
        one = longint'(1) << HueFracBits;
        r = p.red; g = p.green; b = p.blue;
        cmax = (r > g) ? r : g; if (b > cmax) cmax = b;
        cmin = (r < g) ? r : g; if (b < cmin) cmin = b;
        delta = cmax - cmin;
        hue = 0;
        if (delta != 0) begin
            if (cmax == r) begin n = g - b; base = 0; end
            else if (cmax == g) begin n = b - r; base = 2; end
            else begin n = r - g; base = 4; end
            if (n >= 0) hue = base * one + ((n << HueFracBits) / delta);
            else begin
                frac = ((-n) << HueFracBits) / delta;
                hue = base * one - frac;
                if (hue < 0) hue += 6 * one;
            end
            if (hue >= 6 * one) hue = 0;
        end
        l2 = cmax + cmin;
        a = 255 - ((l2 >= 255) ? l2 - 255 : 255 - l2);
        s = (lvl > 256) ? 256 : lvl;
        cs = a * s;
        cd = cs << HueFracBits;
        t = hue % (2 * one);
        w = one - ((t >= one) ? t - one : one - t);
        xd = cs * w;
        den = longint'(256) << HueFracBits;
        md = l2 * den - cd;
        case (hue >> HueFracBits)
            0: begin cr = cd; cg = xd; cb = 0; end
            1: begin cr = xd; cg = cd; cb = 0; end
            2: begin cr = 0; cg = cd; cb = xd; end
            3: begin cr = 0; cg = xd; cb = cd; end
            4: begin cr = xd; cg = 0; cb = cd; end
            default: begin cr = cd; cg = 0; cb = xd; end
        endcase
        q.red = clamp_chan(2 * cr + md, 2 * den);
        q.green = clamp_chan(2 * cg + md, 2 * den);
        q.blue = clamp_chan(2 * cb + md, 2 * den);
        q.alpha = p.alpha;
        q.frame_end = p.frame_end;
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // receiver: stalls in its own pattern, with quiet stretches
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (!stall_enable || (stall_phase % 512) < 100) o_ready <= 1'b1;
        else o_ready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid && o_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("unexpected output transaction at %0t", $time);
                fail_count++;
            end else begin
                e = pending_pixels.pop_front();
                if (o_red_out !== e.red) report_mismatch("red", o_red_out, e.red);
                if (o_green_out !== e.green) report_mismatch("green", o_green_out, e.green);
                if (o_blue_out !== e.blue) report_mismatch("blue", o_blue_out, e.blue);
                if (o_alpha_out !== e.alpha) report_mismatch("alpha", o_alpha_out, e.alpha);
                if (o_frame_end_out !== e.frame_end)
                    report_mismatch("frame_end", o_frame_end_out, e.frame_end);
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
    endtask

    task automatic write_level(logic [8:0] lvl);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sat_level = lvl;
    endtask

    // presents one pixel and holds it until accepted; valid stays up after
    task automatic send_pixel(t_pixel p);
        i_valid <= 1'b1;
        {i_red_in, i_green_in, i_blue_in, i_alpha_in, i_frame_end_in} <= p;
        do @(posedge i_clk); while (!i_ready);
        pending_pixels.push_back(resaturate(p, sat_level));
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel p;
        p = $bits(t_pixel)'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: begin p.green = p.red; p.blue = p.red; end   // grey
            1: p.blue = p.green;                              // green and blue tie
            2: p.red = 8'd255;
            3: p.blue = 8'd0;
            default: ;
        endcase
        return p;
    endfunction

    t_row directed[] = '{
        '{t_pixel'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, NoWrite, 1'b1,
          t_pixel'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
        '{t_pixel'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}, NoWrite, 1'b1,
          t_pixel'{8'd255, 8'd255, 8'd255, 8'd255, 1'b1}},
        '{t_pixel'{8'd255, 8'd0, 8'd0, 8'd170, 1'b0}, NoWrite, 1'b1,
          t_pixel'{8'd255, 8'd0, 8'd0, 8'd170, 1'b0}},
        '{t_pixel'{8'd0, 8'd255, 8'd0, 8'd85, 1'b0}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd0, 8'd0, 8'd255, 8'd1, 1'b1}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd128, 8'd128, 8'd128, 8'd2, 1'b0}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd255, 8'd0, 8'd1, 8'd3, 1'b0}, NoWrite, 1'b0, '0},  // red max, below
        '{t_pixel'{8'd200, 8'd200, 8'd10, 8'd4, 1'b0}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd10, 8'd200, 8'd200, 8'd5, 1'b0}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd200, 8'd10, 8'd200, 8'd6, 1'b0}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd255, 8'd0, 8'd0, 8'd7, 1'b0}, 10'd0, 1'b1,
          t_pixel'{8'd127, 8'd127, 8'd127, 8'd7, 1'b0}},
        '{t_pixel'{8'd90, 8'd30, 8'd60, 8'd8, 1'b1}, NoWrite, 1'b0, '0},
        '{t_pixel'{8'd255, 8'd0, 8'd0, 8'd9, 1'b0}, 10'd511, 1'b1,
          t_pixel'{8'd255, 8'd0, 8'd0, 8'd9, 1'b0}},
        '{t_pixel'{8'd40, 8'd90, 8'd250, 8'd10, 1'b0}, 10'd257, 1'b0, '0},
        '{t_pixel'{8'd40, 8'd90, 8'd250, 8'd11, 1'b0}, 10'd128, 1'b0, '0},
        '{t_pixel'{8'd1, 8'd254, 8'd100, 8'd12, 1'b1}, 10'd1, 1'b0, '0},
        '{t_pixel'{8'd250, 8'd120, 8'd5, 8'd13, 1'b0}, 10'd255, 1'b0, '0}
    };

    initial begin
        logic [8:0] levels[];
        int sent;
        t_pixel p;
        levels = '{9'd256, 9'd0, 9'd511, 9'd64, 9'd200, 9'd257};
        sat_level = SatReset;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].sat != NoWrite) begin
                idle_gap(1);
                write_level(directed[k].sat[8:0]);
            end
            send_pixel(directed[k].pix);
            if (directed[k].has_exp && resaturate(directed[k].pix, sat_level)
                    !== directed[k].exp_pix) begin
                $display("predictor disagrees with table row %0d", k);
                fail_count++;
            end
        end

        sent = 0;
        foreach (levels[j]) begin
            idle_gap(1);
            write_level(levels[j]);
            stall_enable = (j != 2);
            while (sent < (j + 1) * NumRandom / levels.size()) begin
                repeat ($urandom_range(1, 40)) begin
                    p = rand_pixel();
                    send_pixel(p);
                    sent++;
                end
                idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                if (sent % 300 < 20) begin
                    idle_gap(1);
                    wait_drained();
                end
            end
        end
        idle_gap(1);
        wait_drained();

        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
